>>> design/delimited_integer_list_parser_macros.svh
// ----------------------------------------------------------------------------
// delimited_integer_list_parser_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_INTEGER_LIST_PARSER_MACROS_SVH
`define DELIMITED_INTEGER_LIST_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DILP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define DILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilp_pkg
// Shared types for the delimited integer list parser: request payloads,
// result kinds, parser states, range settings and character codes.
// ----------------------------------------------------------------------------
package dilp_pkg;

    localparam int CHAR_W   = 8;
    localparam int NUMBER_W = 32;
    localparam int MODE_W   = 2;

    // range check settings
    localparam logic [MODE_W-1:0] MODE_INT32 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UINT8 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INT8  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // text characters the parser cares about
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // result kinds
    typedef enum logic [2:0] {
        KIND_NUMBER    = 3'd0,
        KIND_END_OK    = 3'd1,
        KIND_END_EMPTY = 3'd2,
        KIND_SYNTAX    = 3'd3,
        KIND_RANGE     = 3'd4
    } kind_t;

    // parser states
    typedef enum logic [2:0] {
        PM_BEFORE  = 3'd0,
        PM_COMMA   = 3'd1,
        PM_SIGN    = 3'd2,
        PM_DIGITS  = 3'd3,
        PM_DISCARD = 3'd4
    } pm_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [NUMBER_W-1:0] number;
        logic                       last;
    } out_item_t;

endpackage

>>> design/delimited_integer_list_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_integer_list_parser
// Parses a character stream into signed decimal integers with range check.
// ----------------------------------------------------------------------------
// Results of a character are written into the result queue when its request is
// accepted and read out on m_ in order. Takes one character per cycle while the
// queue has room for two results; an item giving two results is absorbed by a four-entry result queue.
// Reset (synchronous, aresetn low): parser state cleared, range_mode back to
// signed full width, result queue emptied.
module delimited_integer_list_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [dilp_pkg::MODE_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dilp_pkg::in_item_t         s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dilp_pkg::out_item_t        m_result
);
    import dilp_pkg::*;

    localparam int MAG_W = VALUE_WIDTH + 1;
    localparam int EXT_W = (MAG_W > NUMBER_W) ? MAG_W : NUMBER_W;
    localparam logic [MAG_W-1:0] NEG_MAX_FULL = MAG_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [MAG_W-1:0] POS_MAX_FULL = NEG_MAX_FULL - MAG_W'(1);
    localparam logic [MAG_W-1:0] MAG_CAP = NEG_MAX_FULL + MAG_W'(256);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [MODE_W-1:0] range_mode_reg;
    pm_t               mode_reg, mode_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;

    out_item_t         res [2];
    logic [1:0]        nres;

    out_item_t         fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              accept, pop;
    logic [CHAR_W-1:0] c;
    logic              c_space, c_digit, c_comma, c_sign;
    logic [MAG_W+3:0]  mag_x10;
    logic [MAG_W-1:0]  bound;
    logic              over;
    logic              syn, fin_char;
    logic [EXT_W-1:0]  mag_ext, num_ext;

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;

    // character classes
    assign c       = s_item.char_code;
    assign c_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_comma = (c == CH_COMMA);
    assign c_sign  = (c == CH_PLUS) || (c == CH_MINUS);

    // accumulate one digit: mag * 10 + d, never overflows at this width
    assign mag_x10 = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                   + {{MAG_W{1'b0}}, c[3:0]};

    // range configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_mode_reg <= '0;
        end else if (cfg_we) begin
            range_mode_reg <= cfg_wdata;
        end
    end

    // parse one request: character phase, then end-of-text phase
    always_comb begin
        mode_next = mode_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        syn       = 1'b0;
        fin_char  = 1'b0;
        nres      = '0;
        res[0]    = '0;
        res[1]    = '0;

        if (s_item.has_char) begin
            case (mode_reg)
                PM_BEFORE, PM_COMMA: begin
                    if (c_space) begin
                        mode_next = mode_reg;
                    end else if (c_comma) begin
                        if (mode_reg == PM_COMMA) begin
                            syn = 1'b1;
                        end else begin
                            mode_next = PM_COMMA;
                        end
                    end else if (c_digit) begin
                        mode_next = PM_DIGITS;
                        mag_next  = MAG_W'(c[3:0]);
                        neg_next  = 1'b0;
                    end else if (c_sign) begin
                        mode_next = PM_SIGN;
                        mag_next  = '0;
                        neg_next  = (c == CH_MINUS);
                    end else begin
                        syn = 1'b1;
                    end
                end
                PM_SIGN: begin
                    if (c_digit) begin
                        mode_next = PM_DIGITS;
                        mag_next  = MAG_W'(c[3:0]);
                    end else begin
                        syn = 1'b1;
                    end
                end
                PM_DIGITS: begin
                    if (c_digit) begin
                        mag_next = (mag_x10 > {4'b0, MAG_CAP}) ? MAG_CAP
                                                               : mag_x10[MAG_W-1:0];
                    end else if (c_space || c_comma) begin
                        fin_char = 1'b1;
                    end else begin
                        syn = 1'b1;
                    end
                end
                default: begin
                    mode_next = PM_DISCARD;
                end
            endcase
        end

        // range bound for the sign in hand
        case (range_mode_reg)
            MODE_UINT8: bound = neg_next ? MAG_W'(0) : MAG_W'(255);
            MODE_INT8:  bound = neg_next ? MAG_W'(128) : MAG_W'(127);
            default:    bound = neg_next ? NEG_MAX_FULL : POS_MAX_FULL;
        endcase
        over = (mag_next > bound);

        // signed value, low bits of two's complement
        mag_ext = EXT_W'(mag_next);
        num_ext = neg_next ? (-mag_ext) : mag_ext;

        // number closed by a delimiter, or syntax error
        if (syn) begin
            res[0]    = '{kind: KIND_SYNTAX, number: '0, last: 1'b1};
            nres      = 2'd1;
            mode_next = PM_DISCARD;
        end else if (fin_char) begin
            if (over) begin
                res[0]    = '{kind: KIND_RANGE, number: '0, last: 1'b1};
                mode_next = PM_DISCARD;
            end else begin
                res[0]    = '{kind: KIND_NUMBER, number: signed'(num_ext[NUMBER_W-1:0]),
                              last: 1'b0};
                seen_next = 1'b1;
                mag_next  = '0;
                neg_next  = 1'b0;
                mode_next = c_comma ? PM_COMMA : PM_BEFORE;
            end
            nres = 2'd1;
        end

        // end of text
        if (s_item.end_of_text) begin
            case (mode_next)
                PM_BEFORE, PM_COMMA: begin
                    res[nres[0]] = '{kind: seen_next ? KIND_END_OK : KIND_END_EMPTY,
                                     number: '0, last: 1'b1};
                    nres = nres + 2'd1;
                end
                PM_SIGN: begin
                    res[nres[0]] = '{kind: KIND_SYNTAX, number: '0, last: 1'b1};
                    nres = nres + 2'd1;
                end
                PM_DIGITS: begin
                    if (over) begin
                        res[0] = '{kind: KIND_RANGE, number: '0, last: 1'b1};
                        nres   = 2'd1;
                    end else begin
                        res[0] = '{kind: KIND_NUMBER,
                                   number: signed'(num_ext[NUMBER_W-1:0]), last: 1'b0};
                        res[1] = '{kind: KIND_END_OK, number: '0, last: 1'b1};
                        nres   = 2'd2;
                    end
                end
                default: begin
                    nres = nres;
                end
            endcase
            mode_next = PM_BEFORE;
            mag_next  = '0;
            neg_next  = 1'b0;
            seen_next = 1'b0;
        end
    end

    // parser state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= PM_BEFORE;
            mag_reg  <= '0;
            neg_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            seen_reg <= seen_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (accept && (nres != 2'd0)) begin
            fifo_mem[wr_ptr_reg] <= res[0];
        end
        if (accept && (nres == 2'd2)) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res[1];
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(nres);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(nres) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // room for two results keeps the input open
    assign s_ready  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_valid  = (count_reg != '0);
    assign m_result = fifo_mem[rd_ptr_reg];

endmodule

>>> design/dilp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilp_checker
// Port-level checks for the delimited integer list parser, bound to the top.
// ----------------------------------------------------------------------------
`include "delimited_integer_list_parser_macros.svh"

module dilp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input dilp_pkg::out_item_t         m_result
);
    import dilp_pkg::*;

    logic is_err, is_end, is_close, is_status, stalled;

    assign is_err = (m_result.kind == KIND_SYNTAX) || (m_result.kind == KIND_RANGE);
    assign is_end = (m_result.kind == KIND_END_OK) || (m_result.kind == KIND_END_EMPTY);
    assign is_close  = m_valid && (is_err || is_end);
    assign is_status = m_valid && (m_result.kind != KIND_NUMBER);
    assign stalled   = m_valid && !m_ready;

    // stalled result holds
    `DILP_ASSERT_NEXT(a_hold, stalled, m_valid && $stable(m_result), "stalled result moved")
    // only numbers carry a value
    `DILP_ASSERT_NOW(a_zero, is_status, m_result.number == 0, "value on status result")
    // errors and end status close the text
    `DILP_ASSERT_NOW(a_last, is_close, m_result.last, "closing result without last")
    // empty result queue never blocks requests
    `DILP_ASSERT_NOW(a_ready, !m_valid, s_ready, "input stalled with empty queue")

endmodule

bind delimited_integer_list_parser dilp_checker u_dilp_checker (.*);

>>> verif/dilp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilp_tb_pkg
// Character codes and the result scoreboard for the integer list parser
// bench. The scoreboard tracks the parser state for each accepted request,
// queues the results that the request should produce and checks them in order.
// ----------------------------------------------------------------------------
package dilp_tb_pkg;

    import dilp_pkg::*;

    // characters used only to damage texts
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    // magnitude saturates just above every legal bound
    localparam longint unsigned MAG_CEILING = 64'h0000_0000_8000_0100;

    localparam int MAX_PRINTED = 200;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    class parse_scoreboard;
        logic [MODE_W-1:0] range_mode;
        int                errors;
        pm_t               state;
        longint unsigned   mag;
        bit                neg;
        bit                seen_number;
        out_item_t         want_q[$];

        function new();
            range_mode = MODE_INT32;
            errors     = 0;
            clear_text();
        endfunction

        function void clear_text();
            state       = PM_BEFORE;
            mag         = 0;
            neg         = 1'b0;
            seen_number = 1'b0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void expect_result(kind_t kind, longint unsigned value, bit last);
            out_item_t r;
            r.kind   = kind;
            r.number = value[NUMBER_W-1:0];
            r.last   = last;
            want_q.insert(want_q.size(), r);
        endfunction

        function void syntax_error();
            expect_result(KIND_SYNTAX, 0, 1'b1);
            state = PM_DISCARD;
        endfunction

        // close the number in progress, 0 when it fails the range check
        function bit finish_number();
            longint unsigned pos_lim;
            longint unsigned neg_lim;
            case (range_mode)
                MODE_UINT8: begin
                    pos_lim = 255;
                    neg_lim = 0;
                end
                MODE_INT8: begin
                    pos_lim = 127;
                    neg_lim = 128;
                end
                default: begin
                    neg_lim = 64'd1 << (NUMBER_W - 1);
                    pos_lim = neg_lim - 1;
                end
            endcase
            if (mag > (neg ? neg_lim : pos_lim)) begin
                expect_result(KIND_RANGE, 0, 1'b1);
                state = PM_DISCARD;
                return 1'b0;
            end
            expect_result(KIND_NUMBER, neg ? 64'd0 - mag : mag, 1'b0);
            seen_number = 1'b1;
            mag         = 0;
            neg         = 1'b0;
            return 1'b1;
        endfunction

        function void take_char(logic [7:0] c);
            longint unsigned digit;
            longint unsigned sum;
            digit = longint'(c - CH_ZERO);
            case (state)
                PM_BEFORE, PM_COMMA: begin
                    if (is_blank(c)) begin
                        // whitespace between tokens
                    end else if (c == CH_COMMA) begin
                        if (state == PM_COMMA) begin
                            syntax_error();
                        end else begin
                            state = PM_COMMA;
                        end
                    end else if (is_digit(c)) begin
                        state = PM_DIGITS;
                        mag   = digit;
                        neg   = 1'b0;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        state = PM_SIGN;
                        mag   = 0;
                        neg   = (c == CH_MINUS);
                    end else begin
                        syntax_error();
                    end
                end
                PM_SIGN: begin
                    if (is_digit(c)) begin
                        state = PM_DIGITS;
                        mag   = digit;
                    end else begin
                        syntax_error();
                    end
                end
                PM_DIGITS: begin
                    if (is_digit(c)) begin
                        // saturating accumulate
                        if (mag > MAG_CEILING / 10) begin
                            mag = MAG_CEILING;
                        end else begin
                            sum = mag * 10 + digit;
                            mag = (sum > MAG_CEILING) ? MAG_CEILING : sum;
                        end
                    end else if (is_blank(c) || c == CH_COMMA) begin
                        if (finish_number()) begin
                            state = (c == CH_COMMA) ? PM_COMMA : PM_BEFORE;
                        end
                    end else begin
                        syntax_error();
                    end
                end
                default: begin
                    state = PM_DISCARD;
                end
            endcase
        endfunction

        function void take_end();
            case (state)
                PM_BEFORE, PM_COMMA: begin
                    expect_result(seen_number ? KIND_END_OK : KIND_END_EMPTY, 0, 1'b1);
                end
                PM_SIGN: begin
                    expect_result(KIND_SYNTAX, 0, 1'b1);
                end
                PM_DIGITS: begin
                    if (finish_number()) begin
                        expect_result(KIND_END_OK, 0, 1'b1);
                    end
                end
                default: begin
                    // rest of a failed text gives nothing
                end
            endcase
            clear_text();
        endfunction

        function void note_request(in_item_t req);
            if (req.has_char) begin
                take_char(req.char_code);
            end
            if (req.end_of_text) begin
                take_end();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (want_q.size() == 0) begin
                report($sformatf("result kind %0d number %0d with nothing outstanding",
                                 got.kind, got.number));
                return;
            end
            want = want_q.pop_front();
            if (got.kind !== want.kind) begin
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            end
            if (got.number !== want.number) begin
                report($sformatf("number %0d, want %0d", got.number, want.number));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask
    endclass

endpackage

>>> verif/delimited_integer_list_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_integer_list_parser_tb
// Streams texts through the integer list parser: a short directed set of
// corner texts, then phases of random number lists, damaged lists and byte
// noise under each range mode, with random gaps on both channels. Every
// result is checked in order against the scoreboard prediction.
// ----------------------------------------------------------------------------
module delimited_integer_list_parser_tb;

    import dilp_pkg::*;
    import dilp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;

    localparam logic [MODE_W-1:0] PHASE_MODES [4] = '{MODE_UINT8, MODE_INT8, MODE_SPARE,
                                                       MODE_INT32};

    localparam longint unsigned BOUNDARY_MAGS [16] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd127, 64'd128, 64'd129, 64'd255,
        64'd256, 64'd257, 64'd2147483646, 64'd2147483647, 64'd2147483648,
        64'd2147483649, 64'd2147483904, 64'd4294967296
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [MODE_W-1:0]   cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_item    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_result;

    parse_scoreboard sb = new();
    in_item_t        text_q[$];
    bit              free_run     = 1'b0;
    int              stall_left   = 0;
    int              quiet_cycles = 0;
    int              sent_items   = 0;

    delimited_integer_list_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly no gap, some short, a few long; none while free running
    function automatic int pick_gap();
        int roll;
        if (free_run) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end
    end

    // request and result monitor with the no-progress watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_item);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_result);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[delimited_integer_list_parser] ERROR");
                $finish;
            end
        end
    end

    // append one request to the text under construction
    function automatic void append_item(in_item_t item);
        text_q.insert(text_q.size(), item);
    endfunction

    // text building
    function automatic void add_char(logic [7:0] c);
        append_item('{char_code: c, has_char: 1'b1, end_of_text: 1'b0});
    endfunction

    function automatic void add_noop();
        append_item('{char_code: 8'($urandom_range(0, 255)), has_char: 1'b0,
                      end_of_text: 1'b0});
    endfunction

    function automatic void add_blank();
        case ($urandom_range(0, 3))
            0: add_char(CH_SPACE);
            1: add_char(CH_TAB);
            2: add_char(CH_LF);
            default: add_char(CH_CR);
        endcase
    endfunction

    function automatic void add_separator();
        int pre_blanks;
        int post_blanks;
        bit with_comma;
        pre_blanks  = $urandom_range(0, 2);
        post_blanks = $urandom_range(0, 2);
        with_comma  = ($urandom_range(0, 9) < 6);
        repeat (pre_blanks) add_blank();
        if (with_comma) begin
            add_char(CH_COMMA);
        end
        repeat (post_blanks) add_blank();
        if (!with_comma && pre_blanks + post_blanks == 0) begin
            add_blank();
        end
        if ($urandom_range(0, 9) == 0) begin
            add_noop();
        end
    endfunction

    function automatic void add_number();
        longint unsigned mag;
        string           digits;
        int              roll;
        int              sign_roll;
        sign_roll = $urandom_range(0, 4);
        if (sign_roll < 2) begin
            add_char(CH_MINUS);
        end else if (sign_roll == 2) begin
            add_char(CH_PLUS);
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) add_char(CH_ZERO);
        end
        roll = $urandom_range(0, 99);
        // long digit runs drive the magnitude into saturation
        if (roll < 10) begin
            repeat ($urandom_range(11, 24)) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            return;
        end
        if (roll < 50) begin
            mag = 64'($urandom_range(0, 300));
        end else if (roll < 80) begin
            mag = BOUNDARY_MAGS[4'($urandom_range(0, 15))];
        end else begin
            mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        end
        digits = $sformatf("%0d", mag);
        for (int i = 0; i < digits.len(); i++) begin
            add_char(digits[i]);
        end
    endfunction

    // well-formed list body without its end marker
    function automatic void build_body();
        int count;
        count = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0) begin
            add_blank();
        end
        if ($urandom_range(0, 6) == 0) begin
            add_char(CH_COMMA);
        end
        for (int k = 0; k < count; k++) begin
            if (k > 0) begin
                add_separator();
            end
            add_number();
        end
        if ($urandom_range(0, 3) == 0) begin
            add_separator();
        end
    endfunction

    // overwrite one position (or add one to an empty text) with a likely illegal character
    function automatic void corrupt_body();
        logic [7:0] bad;
        int         pos;
        case ($urandom_range(0, 6))
            0: bad = CH_DOT;
            1: bad = CH_LOWER_E;
            2: bad = CH_UPPER_E;
            3: bad = CH_COMMA;
            4: bad = CH_PLUS;
            5: bad = CH_MINUS;
            default: bad = 8'($urandom_range(0, 255));
        endcase
        if (text_q.size() == 0) begin
            add_char(bad);
        end else begin
            pos = $urandom_range(0, text_q.size() - 1);
            text_q[pos].char_code = bad;
            text_q[pos].has_char  = 1'b1;
        end
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 8)) begin
            append_item('{char_code: 8'($urandom_range(0, 255)),
                          has_char: ($urandom_range(0, 99) < 85), end_of_text: 1'b0});
        end
    endfunction

    // end on the last character or with a bare end marker
    function automatic void close_text(bit on_last);
        if (on_last && text_q.size() > 0) begin
            text_q[text_q.size() - 1].end_of_text = 1'b1;
        end else begin
            append_item('{char_code: 8'($urandom_range(0, 255)), has_char: 1'b0,
                          end_of_text: 1'b1});
        end
    endfunction

    function automatic void load_text(string s, bit on_last);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
        close_text(on_last);
    endfunction

    // one request; valid stays up across back-to-back requests
    task automatic send_item(input in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_item(text_q[i]);
            if (text_q[i].has_char || text_q[i].end_of_text) begin
                sent_items++;
            end
        end
    endtask

    // hold requests until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_range_mode(input logic [MODE_W-1:0] mode);
        wait_drained();
        // let a trailing request with no result clear the pipeline
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.range_mode = mode;
    endtask

    task automatic run_directed();
        // leading comma, negative value, trailing blank, bare end
        load_text(",-5 ", 1'b0);
        send_text();
        // empty text
        load_text("", 1'b0);
        send_text();
        // trailing comma ending the text
        load_text("+7,", 1'b1);
        send_text();
        // second comma is a syntax error, rest discarded
        load_text("1,,2", 1'b1);
        send_text();
        // sign with no digits at the end
        load_text("-", 1'b1);
        send_text();
        // top and bottom byte codes are illegal characters
        text_q.delete();
        add_char(8'hFF);
        close_text(1'b1);
        send_text();
        text_q.delete();
        add_char(8'h00);
        close_text(1'b1);
        send_text();
        // item with neither character nor end
        text_q.delete();
        add_noop();
        send_text();
        // number and end ok from one request
        load_text("9", 1'b1);
        send_text();
    endtask

    initial begin
        int phase_start;
        int roll;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // every phase change drains all results before the write
            write_range_mode(PHASE_MODES[2'(p % 4)]);
            free_run    = (p % 5 == 4);
            phase_start = sent_items;
            while (sent_items - phase_start < ITEMS_PER_PHASE) begin
                text_q.delete();
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    build_body();
                    close_text(1'($urandom_range(0, 1)));
                end else if (roll < 88) begin
                    build_body();
                    corrupt_body();
                    close_text(1'($urandom_range(0, 1)));
                end else begin
                    build_noise();
                    close_text(1'($urandom_range(0, 1)));
                end
                send_text();
            end
        end
        free_run = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (sb.errors == 0) begin
            $display("[delimited_integer_list_parser] OK");
        end else begin
            $display("[delimited_integer_list_parser] ERROR");
        end
        $finish;
    end

endmodule
